// ----- src/sthr_pkg.sv -----
package sthr_pkg;

	localparam int ACC_FRAC_BITS = 8;
	localparam int ACC_W = 24;
	localparam int INC_W = ACC_FRAC_BITS + 10;
	localparam int SUM_W = ((INC_W > ACC_W) ? INC_W : ACC_W) + 1;
	localparam int AXIS_W = 16;
	localparam int GAIN_W = 16;
	localparam int LEVEL_W = 15;
	localparam int TRIG_W = 8;
	localparam int MOVE_W = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int FULL_SCALE = 32767;
	localparam int HALF_DEN = (FULL_SCALE * 256) / 2;

	typedef enum logic [1:0] {
		MODE_GAMEPAD = 2'd0,
		MODE_MOUSE   = 2'd1,
		MODE_DUAL    = 2'd2,
		MODE_SILENT  = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_GAIN    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL = 8'd3;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
	localparam logic [LEVEL_W-1:0] PRESS_RESET = 15'd19660;
	localparam logic [LEVEL_W-1:0] RELEASE_RESET = 15'd13107;

	localparam logic KIND_GAMEPAD = 1'b0;
	localparam logic KIND_MOUSE = 1'b1;

endpackage

// ----- src/sthr_if.sv -----
interface sthr_in_if;
	logic valid;
	logic ready;
	logic signed [sthr_pkg::AXIS_W-1:0] axis_in_x;
	logic signed [sthr_pkg::AXIS_W-1:0] axis_in_y;
	logic signed [sthr_pkg::AXIS_W-1:0] press_in;
	logic host_ready;
	modport source (output valid, axis_in_x, axis_in_y, press_in, host_ready, input ready);
	modport sink (input valid, axis_in_x, axis_in_y, press_in, host_ready, output ready);
endinterface

interface sthr_out_if;
	logic valid;
	logic ready;
	logic report_kind;
	logic signed [sthr_pkg::AXIS_W-1:0] pad_x;
	logic signed [sthr_pkg::AXIS_W-1:0] pad_y;
	logic [sthr_pkg::TRIG_W-1:0] pad_trigger;
	logic button_bit;
	logic signed [sthr_pkg::MOVE_W-1:0] move_x;
	logic signed [sthr_pkg::MOVE_W-1:0] move_y;
	modport source (output valid, report_kind, pad_x, pad_y, pad_trigger, button_bit,
		move_x, move_y, input ready);
	modport sink (input valid, report_kind, pad_x, pad_y, pad_trigger, button_bit,
		move_x, move_y, output ready);
endinterface

interface sthr_cfg_if;
	logic valid;
	logic ready;
	logic [sthr_pkg::CFG_IDX_W-1:0] index;
	logic [sthr_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sthr_axis_scale.sv -----
module sthr_axis_scale (
	input  logic clk,
	input  logic en,
	input  logic signed [sthr_pkg::AXIS_W-1:0] axis,
	input  logic [sthr_pkg::GAIN_W-1:0] gain,
	output logic signed [sthr_pkg::INC_W-1:0] inc_s3
);

	localparam int F = sthr_pkg::ACC_FRAC_BITS;
	localparam int P_W = sthr_pkg::AXIS_W + sthr_pkg::GAIN_W;
	localparam int NUM_W = P_W + F;
	localparam int T_W = NUM_W + 1;
	localparam int U_W = T_W - 8;
	localparam int A_W = U_W - 15;
	localparam int S_W = ((A_W > 15) ? A_W : 15) + 1;
	localparam int A2_W = S_W - 15;

	logic [sthr_pkg::AXIS_W-1:0] mag;
	logic [P_W-1:0] prod_s2;
	logic neg_s2;
	logic [NUM_W-1:0] num;
	logic [T_W-1:0] t;
	logic [U_W-1:0] u;
	logic [A_W-1:0] a;
	logic [S_W-1:0] s;
	logic [A2_W-1:0] a2;
	logic [15:0] s2;
	logic carry;
	logic [A_W-1:0] q;
	logic [A_W:0] q_ext;
	logic [A_W:0] q_sgn;

	assign mag = axis[sthr_pkg::AXIS_W-1] ? (~axis + 16'd1) : axis;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= P_W'(mag) * P_W'(gain);
			neg_s2 <= axis[sthr_pkg::AXIS_W-1];
		end
	end

	// round(p * 2^F / (32767 * 256)): drop the 256, then fold by 2^15 = 32767 + 1
	always_comb begin
		num = {prod_s2, {F{1'b0}}};
		t = T_W'(num) + T_W'(sthr_pkg::HALF_DEN);
		u = t[T_W-1:8];
		a = u[U_W-1:15];
		s = S_W'(a) + S_W'(u[14:0]);
		a2 = s[S_W-1:15];
		s2 = 16'(a2) + 16'(s[14:0]);
		carry = (s2 >= 16'd32767);
		q = a + A_W'(a2) + A_W'(carry);
		q_ext = {1'b0, q};
		q_sgn = neg_s2 ? (~q_ext + 1'b1) : q_ext;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inc_s3 <= $signed(q_sgn[sthr_pkg::INC_W-1:0]);
		end
	end

endmodule

// ----- src/stick_to_hid_report_router.sv -----
// Joystick sample to HID report router. One sample word is accepted every clock cycle
// while no report word waits at the output; each passes a three-stage pipeline (input
// register, gain multiply, rounding divide by full scale) and an output register that
// holds its report word, if any. The press latch, dual phase and Q16.8 mouse
// accumulators are updated in the last stage, so consecutive samples see each other's
// state. When a report word waits at the output the whole pipeline holds.
// Configuration writes are taken in any cycle and act at once on every stage that uses
// them, so make them only while no sample word is in flight.
module stick_to_hid_report_router (
	input  logic clk,
	input  logic arst_n,
	sthr_in_if.sink sample,
	sthr_out_if.source report,
	sthr_cfg_if.sink cfg
);

	localparam int F = sthr_pkg::ACC_FRAC_BITS;
	localparam int ACC_W = sthr_pkg::ACC_W;
	localparam int INC_W = sthr_pkg::INC_W;
	localparam int SUM_W = sthr_pkg::SUM_W;
	localparam int W_W = ACC_W + 1 - F;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2 ** (ACC_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2 ** (ACC_W - 1)));
	localparam logic signed [W_W-1:0] WHOLE_MAX = W_W'(127);
	localparam logic signed [W_W-1:0] WHOLE_MIN = W_W'(-127);

	function automatic logic signed [ACC_W-1:0] integ(logic signed [ACC_W-1:0] acc,
		logic signed [INC_W-1:0] inc);
		logic signed [SUM_W-1:0] sum;
		sum = SUM_W'(acc) + SUM_W'(inc);
		if (sum > SUM_MAX) integ = SUM_MAX[ACC_W-1:0];
		else if (sum < SUM_MIN) integ = SUM_MIN[ACC_W-1:0];
		else integ = sum[ACC_W-1:0];
	endfunction

	function automatic logic signed [7:0] whole_of(logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] biased;
		logic signed [W_W-1:0] w;
		biased = $signed({acc[ACC_W-1], acc})
			+ $signed({1'b0, {(ACC_W - F){1'b0}}, {F{acc[ACC_W-1]}}});
		w = $signed(biased[ACC_W:F]);
		if (w > WHOLE_MAX) whole_of = 8'sd127;
		else if (w < WHOLE_MIN) whole_of = -8'sd127;
		else whole_of = w[7:0];
	endfunction

	sthr_pkg::mode_t mode_q;
	logic [sthr_pkg::GAIN_W-1:0] gain_q;
	logic [sthr_pkg::LEVEL_W-1:0] press_q;
	logic [sthr_pkg::LEVEL_W-1:0] release_q;

	logic latch_q;
	logic phase_q;
	logic signed [ACC_W-1:0] accum_x_q;
	logic signed [ACC_W-1:0] accum_y_q;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [15:0] x_s1, y_s1, z_s1, z_s2, z_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic signed [15:0] padx_s2, pady_s2, padx_s3, pady_s3;
	logic [22:0] tv_s2;
	logic [7:0] trig_s3;
	logic signed [INC_W-1:0] inc_x_s3, inc_y_s3;
	logic [14:0] zc;

	logic [7:0] ta;
	logic [15:0] ts;
	logic [7:0] trig;

	logic latch_nx, active, gamepad, mouse, dual, emit_pad, mouse_send, btn, emit;
	logic signed [ACC_W-1:0] ax_int, ay_int, ax_new, ay_new;
	logic signed [7:0] dx, dy;

	logic rep_valid_q;
	logic kind_q, btn_q;
	logic signed [15:0] padx_q, pady_q;
	logic [7:0] trig_q;
	logic signed [7:0] movex_q, movey_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sthr_pkg::MODE_GAMEPAD;
			gain_q <= sthr_pkg::GAIN_RESET;
			press_q <= sthr_pkg::PRESS_RESET;
			release_q <= sthr_pkg::RELEASE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				sthr_pkg::CFG_MODE: mode_q <= sthr_pkg::mode_t'(cfg.data[1:0]);
				sthr_pkg::CFG_MOUSE_GAIN: gain_q <= cfg.data;
				sthr_pkg::CFG_PRESS_LEVEL: press_q <= cfg.data[14:0];
				sthr_pkg::CFG_RELEASE_LEVEL: release_q <= cfg.data[14:0];
				default: ;
			endcase
		end
	end

	assign en = !rep_valid_q || report.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign zc = z_s1[15] ? 15'd0 : z_s1[14:0];

	always_comb begin
		ta = tv_s2[22:15];
		ts = 16'(ta) + 16'(tv_s2[14:0]);
		trig = ta + 8'(ts >= 16'd32767);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= sample.axis_in_x;
			y_s1 <= sample.axis_in_y;
			z_s1 <= sample.press_in;
			rdy_s1 <= sample.host_ready;
			padx_s2 <= (x_s1 == 16'sh8000) ? -16'sd32767 : x_s1;
			pady_s2 <= (y_s1 == 16'sh8000) ? -16'sd32767 : y_s1;
			tv_s2 <= (23'(zc) * 23'd255) + 23'd16383;
			z_s2 <= z_s1;
			rdy_s2 <= rdy_s1;
			padx_s3 <= padx_s2;
			pady_s3 <= pady_s2;
			trig_s3 <= trig;
			z_s3 <= z_s2;
			rdy_s3 <= rdy_s2;
		end
	end

	sthr_axis_scale u_scale_x (
		.clk(clk), .en(en), .axis(x_s1), .gain(gain_q), .inc_s3(inc_x_s3)
	);

	sthr_axis_scale u_scale_y (
		.clk(clk), .en(en), .axis(y_s1), .gain(gain_q), .inc_s3(inc_y_s3)
	);

	always_comb begin
		if (!latch_q && (z_s3 > $signed({1'b0, press_q}))) latch_nx = 1'b1;
		else if (latch_q && (z_s3 < $signed({1'b0, release_q}))) latch_nx = 1'b0;
		else latch_nx = latch_q;
		active = rdy_s3 && (mode_q != sthr_pkg::MODE_SILENT);
		gamepad = (mode_q == sthr_pkg::MODE_GAMEPAD) || (mode_q == sthr_pkg::MODE_DUAL);
		mouse = (mode_q == sthr_pkg::MODE_MOUSE) || (mode_q == sthr_pkg::MODE_DUAL);
		dual = (mode_q == sthr_pkg::MODE_DUAL);
		emit_pad = dual ? !phase_q : gamepad;
		mouse_send = dual ? phase_q : mouse;
		ax_int = mouse ? integ(accum_x_q, inc_x_s3) : accum_x_q;
		ay_int = mouse ? integ(accum_y_q, inc_y_s3) : accum_y_q;
		dx = mouse_send ? whole_of(ax_int) : 8'sd0;
		dy = mouse_send ? whole_of(ay_int) : 8'sd0;
		ax_new = ax_int - (ACC_W'(dx) <<< F);
		ay_new = ay_int - (ACC_W'(dy) <<< F);
		btn = !gamepad && latch_nx;
		emit = active && (emit_pad || (mouse_send && ((dx != 8'sd0) || (dy != 8'sd0) || btn)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
			phase_q <= 1'b0;
			accum_x_q <= '0;
			accum_y_q <= '0;
		end else if (en && v_s3) begin
			latch_q <= latch_nx;
			if (active) begin
				accum_x_q <= ax_new;
				accum_y_q <= ay_new;
				if (dual) phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_q <= 1'b0;
		end else if (en) begin
			rep_valid_q <= v_s3 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (emit_pad) begin
				kind_q <= sthr_pkg::KIND_GAMEPAD;
				padx_q <= padx_s3;
				pady_q <= pady_s3;
				trig_q <= trig_s3;
				btn_q <= latch_nx;
				movex_q <= '0;
				movey_q <= '0;
			end else begin
				kind_q <= sthr_pkg::KIND_MOUSE;
				padx_q <= '0;
				pady_q <= '0;
				trig_q <= '0;
				btn_q <= btn;
				movex_q <= dx;
				movey_q <= dy;
			end
		end
	end

	assign report.valid = rep_valid_q;
	assign report.report_kind = kind_q;
	assign report.pad_x = padx_q;
	assign report.pad_y = pady_q;
	assign report.pad_trigger = trig_q;
	assign report.button_bit = btn_q;
	assign report.move_x = movex_q;
	assign report.move_y = movey_q;

	a_silent_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3 && (mode_q == sthr_pkg::MODE_SILENT)) |=> !rep_valid_q)
		else $error("report word produced in silent mode");

	a_move_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_valid_q && (kind_q == sthr_pkg::KIND_MOUSE))
			|-> ((movex_q != 8'sh80) && (movey_q != 8'sh80)))
		else $error("mouse delta outside -127..127");

	a_pad_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_valid_q && (kind_q == sthr_pkg::KIND_GAMEPAD))
			|-> ((movex_q == 8'sd0) && (movey_q == 8'sd0)))
		else $error("gamepad report carries mouse motion");

	a_idle_accum: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3 && !rdy_s3) |=> ($stable(accum_x_q) && $stable(accum_y_q)
			&& $stable(phase_q)))
		else $error("accumulator or phase moved while host not ready");

endmodule

// ----- tb/stick_to_hid_report_router_test.sv -----
`timescale 1ns / 1ps

module stick_to_hid_report_router_test;

	localparam int ACC_FRAC_BITS = sthr_pkg::ACC_FRAC_BITS;
	localparam int ACC_W = sthr_pkg::ACC_W;
	localparam int AXIS_W = sthr_pkg::AXIS_W;
	localparam int GAIN_W = sthr_pkg::GAIN_W;
	localparam int LEVEL_W = sthr_pkg::LEVEL_W;
	localparam int TRIG_W = sthr_pkg::TRIG_W;
	localparam int MOVE_W = sthr_pkg::MOVE_W;
	localparam int CFG_IDX_W = sthr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = sthr_pkg::CFG_DATA_W;
	localparam int FULL_SCALE = sthr_pkg::FULL_SCALE;

	localparam int DRAIN = 8;
	localparam int RANDOM_ITEMS = 1800;
	localparam longint PIX_DEN = longint'(FULL_SCALE) * 256;
	localparam longint ACC_TOP = (longint'(1) << (ACC_W - 1)) - 1;
	localparam longint ACC_BOTTOM = -(longint'(1) << (ACC_W - 1));
	localparam logic signed [AXIS_W-1:0] AXIS_FLOOR = -16'sd32767;
	localparam logic signed [AXIS_W-1:0] AXIS_NEG_FULL = 16'sh8000;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] press;
		logic host_ready;
	} sample_word_t;

	typedef struct packed {
		logic report_kind;
		logic signed [AXIS_W-1:0] pad_x;
		logic signed [AXIS_W-1:0] pad_y;
		logic [TRIG_W-1:0] pad_trigger;
		logic button_bit;
		logic signed [MOVE_W-1:0] move_x;
		logic signed [MOVE_W-1:0] move_y;
	} report_word_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE} row_op_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_WORD, CHK_NONE} check_t;
	typedef enum logic [1:0] {STYLE_SPREAD, STYLE_EDGE, STYLE_HELD, STYLE_FINE} style_t;

	typedef struct packed {
		row_op_t op;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		sample_word_t s;
		check_t chk;
		report_word_t w;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sthr_in_if sample_bus();
	sthr_out_if report_bus();
	sthr_cfg_if cfg_bus();

	stick_to_hid_report_router uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_bus),
		.report(report_bus),
		.cfg(cfg_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sthr_pkg::mode_t cur_mode = sthr_pkg::MODE_GAMEPAD;
	logic [GAIN_W-1:0] cur_gain = sthr_pkg::GAIN_RESET;
	logic [LEVEL_W-1:0] cur_press = sthr_pkg::PRESS_RESET;
	logic [LEVEL_W-1:0] cur_release = sthr_pkg::RELEASE_RESET;
	bit latched = 1'b0;
	bit phase = 1'b0;
	logic signed [ACC_W-1:0] acc_x = '0;
	logic signed [ACC_W-1:0] acc_y = '0;

	report_word_t reports_due [$];
	step_row_t opening_rows [$];
	int mismatches = 0;
	bit steady = 1'b0;

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		sthr_pkg::CFG_MODE: cur_mode = sthr_pkg::mode_t'(data[1:0]);
		sthr_pkg::CFG_MOUSE_GAIN: cur_gain = data;
		sthr_pkg::CFG_PRESS_LEVEL: cur_press = data[LEVEL_W-1:0];
		sthr_pkg::CFG_RELEASE_LEVEL: cur_release = data[LEVEL_W-1:0];
		default: ;
		endcase
	endfunction

	function automatic logic signed [ACC_W-1:0] integrate_axis(
			input logic signed [ACC_W-1:0] acc, input logic signed [AXIS_W-1:0] axis);
		longint mag, num, step, sum;
		mag = (axis < 0) ? -longint'(axis) : longint'(axis);
		num = mag * longint'(cur_gain) * (longint'(1) << ACC_FRAC_BITS);
		step = (2 * num + PIX_DEN) / (2 * PIX_DEN);
		if (axis < 0)
			step = -step;
		sum = longint'(acc) + step;
		if (sum > ACC_TOP)
			sum = ACC_TOP;
		if (sum < ACC_BOTTOM)
			sum = ACC_BOTTOM;
		return sum[ACC_W-1:0];
	endfunction

	function automatic int take_pixels(input logic signed [ACC_W-1:0] acc,
			output logic signed [ACC_W-1:0] rest);
		int whole, left;
		whole = int'(acc) / (1 << ACC_FRAC_BITS);
		if (whole > 127)
			whole = 127;
		if (whole < -127)
			whole = -127;
		left = int'(acc) - whole * (1 << ACC_FRAC_BITS);
		rest = left[ACC_W-1:0];
		return whole;
	endfunction

	function automatic bit route_sample(input sample_word_t s, output report_word_t r);
		int zv, trig, dx, dy;
		bit pad_side, mouse_side, send_pad, send_mouse, btn;
		r = '0;
		zv = $signed(s.press);
		if (!latched && zv > int'(cur_press))
			latched = 1'b1;
		else if (latched && zv < int'(cur_release))
			latched = 1'b0;
		if (cur_mode == sthr_pkg::MODE_SILENT || !s.host_ready)
			return 1'b0;
		pad_side = (cur_mode == sthr_pkg::MODE_GAMEPAD || cur_mode == sthr_pkg::MODE_DUAL);
		mouse_side = (cur_mode == sthr_pkg::MODE_MOUSE || cur_mode == sthr_pkg::MODE_DUAL);
		send_pad = pad_side;
		send_mouse = mouse_side;
		if (pad_side && mouse_side) begin
			send_pad = !phase;
			send_mouse = phase;
			phase = !phase;
		end
		if (mouse_side) begin
			acc_x = integrate_axis(acc_x, s.x);
			acc_y = integrate_axis(acc_y, s.y);
		end
		if (send_pad) begin
			trig = ((zv < 0 ? 0 : zv) * 2 * 255 + FULL_SCALE) / (2 * FULL_SCALE);
			r.report_kind = sthr_pkg::KIND_GAMEPAD;
			r.pad_x = (s.x == AXIS_NEG_FULL) ? AXIS_FLOOR : s.x;
			r.pad_y = (s.y == AXIS_NEG_FULL) ? AXIS_FLOOR : s.y;
			r.pad_trigger = trig[TRIG_W-1:0];
			r.button_bit = latched;
			return 1'b1;
		end
		if (send_mouse) begin
			dx = take_pixels(acc_x, acc_x);
			dy = take_pixels(acc_y, acc_y);
			btn = !pad_side && latched;
			if (dx == 0 && dy == 0 && !btn)
				return 1'b0;
			r.report_kind = sthr_pkg::KIND_MOUSE;
			r.button_bit = btn;
			r.move_x = dx[MOVE_W-1:0];
			r.move_y = dy[MOVE_W-1:0];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic step_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		step_row_t t;
		t = '0;
		t.op = ROW_WRITE;
		t.idx = idx;
		t.data = data;
		return t;
	endfunction

	function automatic step_row_t row_free(input int x, y, z, input bit rdy);
		step_row_t t;
		t = '0;
		t.op = ROW_SAMPLE;
		t.s.x = 16'(x);
		t.s.y = 16'(y);
		t.s.press = 16'(z);
		t.s.host_ready = rdy;
		t.chk = CHK_MODEL;
		return t;
	endfunction

	function automatic step_row_t row_quiet(input int x, y, z, input bit rdy);
		step_row_t t;
		t = row_free(x, y, z, rdy);
		t.chk = CHK_NONE;
		return t;
	endfunction

	function automatic step_row_t row_pad(input int x, y, z, input bit rdy,
			input int px, py, trig, input bit btn);
		step_row_t t;
		t = row_free(x, y, z, rdy);
		t.chk = CHK_WORD;
		t.w.report_kind = sthr_pkg::KIND_GAMEPAD;
		t.w.pad_x = 16'(px);
		t.w.pad_y = 16'(py);
		t.w.pad_trigger = 8'(trig);
		t.w.button_bit = btn;
		return t;
	endfunction

	function automatic step_row_t row_mouse(input int x, y, z, input bit rdy,
			input bit btn, input int dx, dy);
		step_row_t t;
		t = row_free(x, y, z, rdy);
		t.chk = CHK_WORD;
		t.w.report_kind = sthr_pkg::KIND_MOUSE;
		t.w.button_bit = btn;
		t.w.move_x = 8'(dx);
		t.w.move_y = 8'(dy);
		return t;
	endfunction

	function automatic logic signed [AXIS_W-1:0] pick_axis(input style_t style,
			input bit negative);
		logic signed [AXIS_W-1:0] v;
		case (style)
		STYLE_EDGE: begin
			case ($urandom_range(5))
			0: v = 16'sd32767;
			1: v = AXIS_FLOOR;
			2: v = AXIS_NEG_FULL;
			3: v = '0;
			4: v = 16'sd1;
			default: v = -16'sd1;
			endcase
		end
		STYLE_HELD: begin
			v = 16'($urandom_range(32767, 28000));
			if (negative)
				v = ($urandom_range(7) == 0) ? AXIS_NEG_FULL : -v;
		end
		STYLE_FINE: v = 16'(int'($urandom_range(600)) - 300);
		default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic signed [AXIS_W-1:0] pick_press();
		case ($urandom_range(4))
		0: return 16'(int'(cur_press) + int'($urandom_range(4)) - 2);
		1: return 16'(int'(cur_release) + int'($urandom_range(4)) - 2);
		2: return $urandom_range(1) ? 16'sd32767 : AXIS_NEG_FULL;
		3: return 16'($urandom_range(32767));
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(3))
		0: return '0;
		1: return 15'h7FFF;
		default: return 15'($urandom);
		endcase
	endfunction

	task automatic settle();
		sample_bus.valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		apply_reg(idx, data);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_sample(input sample_word_t s, input check_t chk,
			input report_word_t typed);
		report_word_t word;
		bit produced;
		while (!steady && $urandom_range(99) < 11) begin
			sample_bus.valid <= 1'b0;
			sample_bus.axis_in_x <= 16'($urandom);
			sample_bus.axis_in_y <= 16'($urandom);
			sample_bus.press_in <= 16'($urandom);
			sample_bus.host_ready <= 1'($urandom);
			@(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.axis_in_x <= s.x;
		sample_bus.axis_in_y <= s.y;
		sample_bus.press_in <= s.press;
		sample_bus.host_ready <= s.host_ready;
		do @(posedge clk); while (!sample_bus.ready);
		produced = route_sample(s, word);
		if (chk == CHK_WORD)
			reports_due.push_back(typed);
		else if (chk == CHK_MODEL && produced)
			reports_due.push_back(word);
	endtask

	always @(posedge clk)
		report_bus.ready <= steady || ($urandom_range(99) >= 11);

	always @(posedge clk) begin : watch
		report_word_t want;
		if (arst_n && report_bus.valid && report_bus.ready) begin
			if (reports_due.size() == 0) begin
				$error("report word with none expected");
				mismatches++;
			end else begin
				want = reports_due.pop_front();
				if (report_bus.report_kind !== want.report_kind) begin
					$error("report_kind: expected %0d, got %0d", want.report_kind,
						report_bus.report_kind);
					mismatches++;
				end
				if (report_bus.pad_x !== want.pad_x) begin
					$error("pad_x: expected %0d, got %0d", want.pad_x, report_bus.pad_x);
					mismatches++;
				end
				if (report_bus.pad_y !== want.pad_y) begin
					$error("pad_y: expected %0d, got %0d", want.pad_y, report_bus.pad_y);
					mismatches++;
				end
				if (report_bus.pad_trigger !== want.pad_trigger) begin
					$error("pad_trigger: expected %0d, got %0d", want.pad_trigger,
						report_bus.pad_trigger);
					mismatches++;
				end
				if (report_bus.button_bit !== want.button_bit) begin
					$error("button_bit: expected %0d, got %0d", want.button_bit,
						report_bus.button_bit);
					mismatches++;
				end
				if (report_bus.move_x !== want.move_x) begin
					$error("move_x: expected %0d, got %0d", want.move_x, report_bus.move_x);
					mismatches++;
				end
				if (report_bus.move_y !== want.move_y) begin
					$error("move_y: expected %0d, got %0d", want.move_y, report_bus.move_y);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int p, n, sent;
		logic [GAIN_W-1:0] gain;
		logic [LEVEL_W-1:0] lvl_a, lvl_b;
		sthr_pkg::mode_t next_mode;
		style_t style;
		bit negative;
		sample_word_t s;

		arst_n = 1'b0;
		sample_bus.valid = 1'b0;
		sample_bus.axis_in_x = '0;
		sample_bus.axis_in_y = '0;
		sample_bus.press_in = '0;
		sample_bus.host_ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;

		opening_rows.push_back(row_pad(32767, -32767, 32767, 1, 32767, -32767, 255, 1));
		opening_rows.push_back(row_pad(-32768, -32768, -32768, 1, -32767, -32767, 0, 0));
		opening_rows.push_back(row_quiet(0, 0, 32767, 0));
		opening_rows.push_back(row_pad(0, 0, 15000, 1, 0, 0, 117, 1));
		opening_rows.push_back(row_free(-1, 1, 13106, 1));
		opening_rows.push_back(row_free(100, -100, 19660, 1));
		opening_rows.push_back(row_free(5, 5, 19661, 1));
		opening_rows.push_back(row_free(0, 0, 13107, 1));
		opening_rows.push_back(row_free(0, 0, 16384, 1));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_PRESS_LEVEL, 16'd100));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_RELEASE_LEVEL, 16'd20000));
		opening_rows.push_back(row_free(0, 0, 5000, 1));
		opening_rows.push_back(row_free(0, 0, 150, 1));
		opening_rows.push_back(row_free(0, 0, 150, 1));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_PRESS_LEVEL, 16'(sthr_pkg::PRESS_RESET)));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_RELEASE_LEVEL,
			16'(sthr_pkg::RELEASE_RESET)));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_MODE, 16'(sthr_pkg::MODE_MOUSE)));
		opening_rows.push_back(row_mouse(32767, -32767, 0, 1, 0, 1, -1));
		opening_rows.push_back(row_quiet(0, 0, 0, 1));
		opening_rows.push_back(row_free(16384, -16384, 32767, 1));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_MOUSE_GAIN, 16'hFFFF));
		opening_rows.push_back(row_mouse(32767, 32767, 32767, 1, 1, 127, 127));
		opening_rows.push_back(row_free(-32768, -32768, 0, 1));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_MOUSE_GAIN, 16'h0000));
		opening_rows.push_back(row_free(32767, 32767, 0, 1));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_MODE, 16'(sthr_pkg::MODE_DUAL)));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_MOUSE_GAIN, 16'(sthr_pkg::GAIN_RESET)));
		opening_rows.push_back(row_free(1000, 2000, 30000, 1));
		opening_rows.push_back(row_free(32767, -32767, 30000, 1));
		opening_rows.push_back(row_free(0, 0, 0, 0));
		opening_rows.push_back(row_free(-32767, 32767, 0, 1));
		opening_rows.push_back(row_free(0, 0, 0, 1));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_MODE, 16'(sthr_pkg::MODE_SILENT)));
		opening_rows.push_back(row_quiet(32767, -32768, 32767, 1));
		opening_rows.push_back(row_quiet(0, 0, 32767, 0));
		opening_rows.push_back(row_cfg(sthr_pkg::CFG_MODE, {14'h3FFC, sthr_pkg::MODE_GAMEPAD}));
		opening_rows.push_back(row_pad(0, 0, 15000, 1, 0, 0, 117, 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_rows[i]) begin
			if (opening_rows[i].op == ROW_WRITE)
				write_reg(opening_rows[i].idx, opening_rows[i].data);
			else
				send_sample(opening_rows[i].s, opening_rows[i].chk, opening_rows[i].w);
		end

		p = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			steady = (p >= 5 && p <= 7);
			next_mode = (p < 8) ? sthr_pkg::mode_t'(p % 4) : sthr_pkg::mode_t'($urandom_range(3));
			write_reg(sthr_pkg::CFG_MODE, {14'($urandom), next_mode});

			if (p == 2 || p == 6 || $urandom_range(9) == 0)
				gain = 16'hFFFF;
			else if (p == 3 || $urandom_range(9) == 0)
				gain = '0;
			else
				gain = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1024));
			if (p < 8 || $urandom_range(1))
				write_reg(sthr_pkg::CFG_MOUSE_GAIN, gain);

			if (p == 1) begin
				lvl_a = '0;
				lvl_b = '0;
			end else if (p == 4) begin
				lvl_a = 15'h7FFF;
				lvl_b = 15'h7FFF;
			end else if (p == 5) begin
				lvl_a = 15'($urandom_range(8000));
				lvl_b = 15'($urandom_range(32767, 20000));
			end else begin
				lvl_a = pick_level();
				lvl_b = pick_level();
			end
			if (p < 8 || $urandom_range(1))
				write_reg(sthr_pkg::CFG_PRESS_LEVEL, {1'($urandom), lvl_a});
			if (p < 8 || $urandom_range(1))
				write_reg(sthr_pkg::CFG_RELEASE_LEVEL, {1'($urandom), lvl_b});
			if ($urandom_range(3) == 0)
				write_reg(8'($urandom_range(255, 4)), 16'($urandom));

			style = (p == 2 || p == 6) ? STYLE_HELD : style_t'($urandom_range(3));
			negative = (p == 6) || (p > 8 && $urandom_range(1));
			n = (style == STYLE_HELD) ? 250 : $urandom_range(180, 60);
			repeat (n) begin
				s.x = pick_axis(style, negative);
				s.y = pick_axis(style, negative);
				s.press = pick_press();
				s.host_ready = ($urandom_range(99) < 85);
				send_sample(s, CHK_MODEL, '0);
			end
			sent += n;
			p++;
		end

		steady = 1'b0;
		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
src/sthr_pkg.sv
src/sthr_if.sv
src/sthr_axis_scale.sv
src/stick_to_hid_report_router.sv
tb/stick_to_hid_report_router_test.sv
